// ----- rtl/core/csa_pkg.sv -----
// Shared types and constants of the contiguous sector allocator.
// Used by csa_cell, csa_ctrl and the top level; depends on nothing.
package csa_pkg;

	localparam int NUM_SECTORS_DEF  = 32;
	localparam int SECTOR_BYTES_DEF = 10240;

	// Index, count, run-byte and handle-value widths sized for the largest table (64 sectors of up to 1 MiB each)
	localparam int SIZE_W   = 24;
	localparam int HANDLE_W = 9;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int RB_W     = 27;
	localparam int HV_W     = 10;

	localparam logic [1:0] MARK_FREE   = 2'd0;
	localparam logic [1:0] MARK_HEAD   = 2'd1;
	localparam logic [1:0] MARK_FOLLOW = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_RUN     = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE   = 2'd2;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// Search/release wave that moves one cell per cycle
	typedef struct packed {
		logic                valid;
		logic                op_free;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
		logic [RB_W-1:0]     run_bytes;
		logic [CNT_W-1:0]    run;
		logic                found;
		logic [IDX_W-1:0]    end_idx;
		logic                clearing;
		logic                hit;
	} wave_t;

	// Mark a found run: lo becomes head, lo+1..hi become followers
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
	} commit_t;

endpackage

// ----- rtl/core/contiguous_sector_allocator.sv -----
// First-fit contiguous sector allocator: controller plus a chain of sector cells.
// Depends on csa_pkg, csa_cell and csa_ctrl.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: req_type 0
//   allocates size_bytes rounded up to whole sectors, req_type 1 frees the
//   allocation named by handle_in = (head index + 1) * 10.
//   Output channel (out_valid/out_ready) returns exactly one item per request:
//   handle_out (the new handle, zero on failure or free) and status
//   (0 ok, 1 no free run, 2 bad size, 3 bad handle).
// Timing:
//   A request walks a wave down the row of NUM_SECTORS cells, one cell per
//   cycle. The result becomes valid in the output register, and in_ready
//   rises, in the same cycle. Allocates with a size of zero or larger than
//   the table skip the scan and go straight to S_DONE. One item is in
//   flight at a time; in_ready is high only while the sequencer is idle.
// Reset:
//   arst_n clears every sector mark to free at once; no sweep is needed.
// Backpressure:
//   The result sits in an output register. A new item may be accepted and
//   scanned while that result waits; the finished second result then holds
//   until out_ready frees the output register.
module contiguous_sector_allocator import csa_pkg::*; #(
	parameter int NUM_SECTORS  = NUM_SECTORS_DEF,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [SIZE_W-1:0]   size_bytes,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [1:0]          status
);

	// wave_chain[k] feeds cell k; wave_chain[NUM_SECTORS] leaves the last cell
	wave_t   wave_chain [NUM_SECTORS+1];
	commit_t commit;

	csa_ctrl #(
		.NUM_SECTORS  (NUM_SECTORS),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.size_bytes (size_bytes),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.handle_out (handle_out),
		.status     (status),
		.launch     (wave_chain[0]),
		.chain_end  (wave_chain[NUM_SECTORS]),
		.commit     (commit)
	);

	// Each cell owns one sector mark and hands the wave to its right neighbor
	for (genvar k = 0; k < NUM_SECTORS; k++) begin : g_cell
		csa_cell #(
			.IDX          (k),
			.SECTOR_BYTES (SECTOR_BYTES)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wave_i (wave_chain[k]),
			.commit (commit),
			.wave_o (wave_chain[k+1])
		);
	end

endmodule

// ----- rtl/core/csa_cell.sv -----
// One sector of the allocator: holds its mark and forwards the wave.
// Depends on csa_pkg.
module csa_cell import csa_pkg::*; #(
	parameter int IDX          = 0,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  wave_t   wave_i,
	input  commit_t commit,
	output wave_t   wave_o
);

	localparam logic [IDX_W-1:0]  MY_IDX    = IDX_W'(IDX);
	localparam logic [HV_W-1:0]   MY_HANDLE = HV_W'((IDX + 1) * 10);
	localparam logic [RB_W-1:0]   SEC_BYTES = RB_W'(SECTOR_BYTES);

	logic [1:0] mark_q;
	logic [1:0] mark_d;
	wave_t      wave_q;
	wave_t      wave_d;
	logic       hit_idx;

	assign hit_idx = ({1'b0, wave_i.handle} == MY_HANDLE);

	always_comb begin
		wave_d = wave_i;
		mark_d = mark_q;
		if (wave_i.valid) begin
			if (wave_i.op_free == REQ_ALLOC) begin
				if (!wave_i.found) begin
					if (mark_q == MARK_FREE) begin
						wave_d.run_bytes = wave_i.run_bytes + SEC_BYTES;
						wave_d.run       = wave_i.run + CNT_W'(1);
						if (wave_d.run_bytes >= RB_W'(wave_i.size)) begin
							wave_d.found   = 1'b1;
							wave_d.end_idx = MY_IDX;
						end
					end else begin
						wave_d.run_bytes = '0;
						wave_d.run       = '0;
					end
				end
			end else begin
				wave_d.clearing = 1'b0;
				if (hit_idx && mark_q == MARK_HEAD) begin
					wave_d.hit      = 1'b1;
					wave_d.clearing = 1'b1;
					mark_d          = MARK_FREE;
				end else if (wave_i.clearing && mark_q == MARK_FOLLOW) begin
					wave_d.clearing = 1'b1;
					mark_d          = MARK_FREE;
				end
			end
		end
		if (commit.en && MY_IDX >= commit.lo && MY_IDX <= commit.hi) begin
			mark_d = (MY_IDX == commit.lo) ? MARK_HEAD : MARK_FOLLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= MARK_FREE;
			wave_q <= '0;
		end else begin
			mark_q <= mark_d;
			wave_q <= wave_d;
		end
	end

	assign wave_o = wave_q;

endmodule

// ----- rtl/core/csa_ctrl.sv -----
// Request sequencer: launches the wave, reads it at the chain end, commits
// allocations and holds the result. Depends on csa_pkg.
module csa_ctrl import csa_pkg::*; #(
	parameter int NUM_SECTORS  = NUM_SECTORS_DEF,
	parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [SIZE_W-1:0]   size_bytes,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [1:0]          status,
	output wave_t               launch,
	input  wave_t               chain_end,
	output commit_t             commit
);

	localparam logic [RB_W-1:0] MAX_BYTES = RB_W'(NUM_SECTORS * SECTOR_BYTES);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t              state_q;
	wave_t               launch_q;
	commit_t             commit_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [1:0]          res_status_q;
	logic                out_valid_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [1:0]          status_q;
	logic                accept;
	logic                bad_size;
	logic                out_free;
	logic                launch_go;
	logic                commit_go;
	logic                load_out;
	logic [CNT_W-1:0]    head;
	logic [HV_W-1:0]     head_p1;
	logic [HV_W-1:0]     handle_v;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign bad_size = (size_bytes == '0) || (RB_W'(size_bytes) > MAX_BYTES);
	assign out_free = !out_valid_q || out_ready;

	// Start a wave for every accepted item except a badly sized allocate
	assign launch_go = accept && !(req_type == REQ_ALLOC && bad_size);
	// Mark the run once a successful allocate wave leaves the chain
	assign commit_go = (state_q == S_SCAN) && chain_end.valid
		&& (chain_end.op_free == REQ_ALLOC) && chain_end.found;
	// Move the finished result into the output register when it is free
	assign load_out  = (state_q == S_DONE) && out_free;

	// head = end + 1 - run; handle = (head + 1) * 10
	assign head     = CNT_W'(chain_end.end_idx) + CNT_W'(1) - chain_end.run;
	assign head_p1  = HV_W'(head) + HV_W'(1);
	assign handle_v = (head_p1 << 3) + (head_p1 << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launch_q     <= '0;
			commit_q     <= '0;
			res_handle_q <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			handle_q     <= '0;
			status_q     <= ST_OK;
		end else begin
			launch_q.valid <= launch_go;
			commit_q.en    <= commit_go;
			out_valid_q    <= load_out || (out_valid_q && !out_ready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						launch_q.op_free   <= req_type;
						launch_q.size      <= size_bytes;
						launch_q.handle    <= handle_in;
						launch_q.run_bytes <= '0;
						launch_q.run       <= '0;
						launch_q.found     <= 1'b0;
						launch_q.end_idx   <= '0;
						launch_q.clearing  <= 1'b0;
						launch_q.hit       <= 1'b0;
						if (req_type == REQ_ALLOC && bad_size) begin
							res_handle_q <= '0;
							res_status_q <= ST_BAD_SIZE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (chain_end.valid) begin
						if (chain_end.op_free == REQ_FREE) begin
							res_handle_q <= '0;
							res_status_q <= chain_end.hit ? ST_OK : ST_BAD_HANDLE;
						end else if (chain_end.found) begin
							res_handle_q <= HANDLE_W'(handle_v);
							res_status_q <= ST_OK;
							commit_q.lo  <= IDX_W'(head);
							commit_q.hi  <= chain_end.end_idx;
						end else begin
							res_handle_q <= '0;
							res_status_q <= ST_NO_RUN;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						handle_q <= res_handle_q;
						status_q <= res_status_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign launch     = launch_q;
	assign commit     = commit_q;
	assign out_valid  = out_valid_q;
	assign handle_out = handle_q;
	assign status     = status_q;

endmodule

// ----- tb/contiguous_sector_allocator_tb.sv -----
// Self-checking testbench for the first-fit contiguous sector allocator.
// Drives a directed table (typed or sector-map replies), then random request traffic
// checked against a behavioral sector map; depends on csa_pkg and contiguous_sector_allocator.
`timescale 1ns / 1ps

module contiguous_sector_allocator_tb;
	import csa_pkg::*;

	localparam int NUM_SECTORS  = NUM_SECTORS_DEF;
	localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1525;
	// Covers a full scan plus the output register
	localparam int SETTLE_CYCLES = NUM_SECTORS + 8;
	// Longest honest quiet spell is a sender gap plus a scan plus a receiver stall
	localparam int WATCHDOG_LIMIT = 2000;

	// One row of the directed table. When check_fixed is set, the expected
	// reply is the one typed into the row; otherwise the sector map decides.
	typedef struct packed {
		logic                req;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
		logic                check_fixed;
		logic [HANDLE_W-1:0] fixed_handle;
		logic [1:0]          fixed_status;
	} stim_row_t;

	typedef struct {
		logic [HANDLE_W-1:0] handle;
		logic [1:0]          status;
	} alloc_reply_t;

	localparam int DIRECTED_COUNT = 26;
	localparam int SB = SECTOR_BYTES;

	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// zero size, all-ones size and one sector too many are all bad sizes
		'{REQ_ALLOC, 24'd0,        9'd0,   1'b1, 9'd0,  ST_BAD_SIZE},
		'{REQ_ALLOC, 24'hFFFFFF,   9'h1FF, 1'b1, 9'd0,  ST_BAD_SIZE},
		'{REQ_ALLOC, 24'(32*SB+1), 9'd0,   1'b1, 9'd0,  ST_BAD_SIZE},
		// the whole table in one run, then nothing left
		'{REQ_ALLOC, 24'(32*SB),   9'h1FF, 1'b1, 9'd10, ST_OK},
		'{REQ_ALLOC, 24'd1,        9'd0,   1'b1, 9'd0,  ST_NO_RUN},
		'{REQ_FREE,  24'hFFFFFF,   9'd10,  1'b1, 9'd0,  ST_OK},
		// double free, zero handle, not a multiple of ten, past the table
		'{REQ_FREE,  24'd0,        9'd10,  1'b1, 9'd0,  ST_BAD_HANDLE},
		'{REQ_FREE,  24'd0,        9'd0,   1'b1, 9'd0,  ST_BAD_HANDLE},
		'{REQ_FREE,  24'd0,        9'd15,  1'b1, 9'd0,  ST_BAD_HANDLE},
		'{REQ_FREE,  24'd0,        9'd330, 1'b1, 9'd0,  ST_BAD_HANDLE},
		'{REQ_FREE,  24'hFFFFFF,   9'h1FF, 1'b1, 9'd0,  ST_BAD_HANDLE},
		'{REQ_ALLOC, 24'd1,        9'd0,   1'b1, 9'd10, ST_OK},
		// exact sector size, then one byte over a sector boundary
		'{REQ_ALLOC, 24'(SB),      9'd0,   1'b0, 9'd0,  ST_OK},
		'{REQ_ALLOC, 24'(SB+1),    9'd0,   1'b0, 9'd0,  ST_OK},
		// a follower is not a head
		'{REQ_FREE,  24'd0,        9'd40,  1'b1, 9'd0,  ST_BAD_HANDLE},
		'{REQ_FREE,  24'd0,        9'd20,  1'b0, 9'd0,  ST_OK},
		// the one-sector hole is too short, so first fit skips it
		'{REQ_ALLOC, 24'(2*SB),    9'd0,   1'b0, 9'd0,  ST_OK},
		'{REQ_ALLOC, 24'd5,        9'd0,   1'b0, 9'd0,  ST_OK},
		// a run that would spill past the last sector is refused
		'{REQ_ALLOC, 24'(28*SB),   9'd0,   1'b0, 9'd0,  ST_OK},
		'{REQ_ALLOC, 24'(26*SB),   9'd0,   1'b0, 9'd0,  ST_OK},
		'{REQ_FREE,  24'd0,        9'd320, 1'b0, 9'd0,  ST_OK},
		// release stops at the next head, and at the end of the table
		'{REQ_FREE,  24'd0,        9'd30,  1'b0, 9'd0,  ST_OK},
		'{REQ_FREE,  24'd0,        9'd70,  1'b0, 9'd0,  ST_OK},
		'{REQ_FREE,  24'd0,        9'd50,  1'b0, 9'd0,  ST_OK},
		'{REQ_FREE,  24'd0,        9'd20,  1'b0, 9'd0,  ST_OK},
		'{REQ_FREE,  24'd0,        9'd10,  1'b0, 9'd0,  ST_OK}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                req_type;
	logic [SIZE_W-1:0]   size_bytes;
	logic [HANDLE_W-1:0] handle_in;
	logic                out_valid;
	logic                out_ready;
	logic [HANDLE_W-1:0] handle_out;
	logic [1:0]          status;

	logic [1:0]   sector_map [NUM_SECTORS];
	alloc_reply_t awaited_results [$];
	int           mismatch_count;
	int           quiet_cycles;
	int           sender_calm_left;
	int           ready_left;

	contiguous_sector_allocator #(
		.NUM_SECTORS (NUM_SECTORS),
		.SECTOR_BYTES(SECTOR_BYTES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.size_bytes(size_bytes),
		.handle_in (handle_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.handle_out(handle_out),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the sector map and work out the reply it earns.
	function automatic void predict_request(input logic req, input logic [SIZE_W-1:0] size,
			input logic [HANDLE_W-1:0] handle, output alloc_reply_t reply);
		longint need;
		int     run;
		int     head;
		int     idx;
		bit     found;

		reply.handle = '0;
		if (req == REQ_ALLOC) begin
			need = (longint'(size) + SECTOR_BYTES - 1) / SECTOR_BYTES;
			if (size == 0 || need > NUM_SECTORS) begin
				reply.status = ST_BAD_SIZE;
			end else begin
				reply.status = ST_NO_RUN;
				run = 0;
				found = 1'b0;
				// first fit: take the first run of free sectors long enough
				for (int i = 0; i < NUM_SECTORS; i++) begin
					if (!found) begin
						if (sector_map[i] == MARK_FREE) begin
							run++;
							if (run == need) begin
								head = i + 1 - int'(need);
								sector_map[head] = MARK_HEAD;
								for (int k = head + 1; k <= i; k++)
									sector_map[k] = MARK_FOLLOW;
								reply.handle = HANDLE_W'((head + 1) * 10);
								reply.status = ST_OK;
								found = 1'b1;
							end
						end else begin
							run = 0;
						end
					end
				end
			end
		end else begin
			idx = int'(handle) / 10 - 1;
			if (handle == 0 || handle % 10 != 0 || idx >= NUM_SECTORS
					|| sector_map[idx] != MARK_HEAD) begin
				reply.status = ST_BAD_HANDLE;
			end else begin
				// release the head, then the followers directly behind it
				sector_map[idx] = MARK_FREE;
				idx++;
				while (idx < NUM_SECTORS && sector_map[idx] == MARK_FOLLOW) begin
					sector_map[idx] = MARK_FREE;
					idx++;
				end
				reply.status = ST_OK;
			end
		end
	endfunction

	// Pick a random sector that carries the given mark, or -1 if there is none.
	function automatic int pick_sector(input logic [1:0] mark);
		int hits;
		int chosen;

		hits = 0;
		for (int i = 0; i < NUM_SECTORS; i++)
			if (sector_map[i] == mark)
				hits++;
		if (hits == 0)
			return -1;
		chosen = $urandom_range(0, hits - 1);
		for (int i = 0; i < NUM_SECTORS; i++) begin
			if (sector_map[i] == mark) begin
				if (chosen == 0)
					return i;
				chosen--;
			end
		end
		return -1;
	endfunction

	// Sender gap: mostly none or short, a few long, with calm stretches of none.
	function automatic int pick_gap();
		int r;

		if (sender_calm_left > 0) begin
			sender_calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			sender_calm_left = $urandom_range(30, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Present one item, hold it until accepted, then record the reply it must get.
	task automatic issue_item(input logic req, input logic [SIZE_W-1:0] size,
			input logic [HANDLE_W-1:0] handle, input logic check_fixed,
			input logic [HANDLE_W-1:0] fixed_handle, input logic [1:0] fixed_status);
		int           gap;
		alloc_reply_t reply;

		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		size_bytes <= size;
		handle_in  <= handle;
		do @(posedge clk); while (!in_ready);
		// the map advances on every accepted item, typed rows included
		predict_request(req, size, handle, reply);
		if (check_fixed) begin
			reply.handle = fixed_handle;
			reply.status = fixed_status;
		end
		awaited_results.push_back(reply);
	endtask

	// Hold the sender off until every outstanding reply has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// Stimulus: reset, the directed table, then random traffic.
	initial begin
		int                  r;
		int                  need;
		int                  pick;
		logic                req;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;

		arst_n           = 1'b0;
		in_valid         = 1'b0;
		req_type         = REQ_ALLOC;
		size_bytes       = '0;
		handle_in        = '0;
		mismatch_count   = 0;
		sender_calm_left = 0;
		for (int i = 0; i < NUM_SECTORS; i++)
			sector_map[i] = MARK_FREE;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++)
			issue_item(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].size, DIRECTED_ROWS[i].handle,
				DIRECTED_ROWS[i].check_fixed, DIRECTED_ROWS[i].fixed_handle,
				DIRECTED_ROWS[i].fixed_status);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// now and then let the pipe run completely dry
			if (n % 250 == 125)
				drain_results();
			r      = $urandom_range(0, 99);
			req    = REQ_ALLOC;
			size   = SIZE_W'($urandom);
			handle = HANDLE_W'($urandom_range(0, 511));
			pick   = (r >= 45 && r < 80) ? pick_sector(MARK_HEAD) : -1;
			if (r < 45 || (r < 80 && pick < 0)) begin
				// well-formed allocate, sizes landing on and around sector edges
				need = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
					: $urandom_range(5, NUM_SECTORS);
				case ($urandom_range(0, 9))
					0:       size = SIZE_W'(need * SECTOR_BYTES);
					1:       size = SIZE_W'((need - 1) * SECTOR_BYTES + 1);
					default: size = SIZE_W'((need - 1) * SECTOR_BYTES
						+ $urandom_range(1, SECTOR_BYTES));
				endcase
			end else if (r < 80) begin
				// release a live allocation
				req    = REQ_FREE;
				handle = HANDLE_W'((pick + 1) * 10);
			end else if (r < 88) begin
				// any size at all, mostly far too large, sometimes zero
				size = ($urandom_range(0, 7) == 0) ? '0 : SIZE_W'($urandom_range(0, 24'hFFFFFF));
			end else if (r < 96) begin
				// raw handle noise, or a follower posing as a head
				req  = REQ_FREE;
				pick = pick_sector(MARK_FOLLOW);
				if (pick >= 0 && $urandom_range(0, 1) == 1)
					handle = HANDLE_W'((pick + 1) * 10);
			end else begin
				// tidy handle that may point past the table or at a free sector
				req    = REQ_FREE;
				handle = HANDLE_W'($urandom_range(0, 51) * 10);
			end
			issue_item(req, size, handle, 1'b0, '0, '0);
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Receiver: stall at random, mostly briefly, sometimes long, with open stretches.
	initial begin
		int r;

		out_ready  = 1'b0;
		ready_left = 0;
		forever begin
			@(posedge clk);
			if (ready_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready  <= 1'b1;
					ready_left = $urandom_range(1, 8);
				end else if (r < 68) begin
					out_ready  <= 1'b1;
					ready_left = $urandom_range(40, 150);
				end else if (r < 95) begin
					out_ready  <= 1'b0;
					ready_left = $urandom_range(1, 4);
				end else begin
					out_ready  <= 1'b0;
					ready_left = $urandom_range(20, 80);
				end
			end
			ready_left--;
		end
	end

	// Compare every accepted result with the oldest outstanding reply.
	always @(posedge clk) begin
		alloc_reply_t want;

		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing outstanding: handle_out %0d, status %0d",
					$time, handle_out, status);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (handle_out !== want.handle) begin
					$display("%0t: handle_out expected %0d, actual %0d",
						$time, want.handle, handle_out);
					mismatch_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d, actual %0d",
						$time, want.status, status);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: drop the run if no item moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no item moved for %0d cycles", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule

// ----- sim.f -----
rtl/core/csa_pkg.sv
rtl/core/csa_cell.sv
rtl/core/csa_ctrl.sv
rtl/core/contiguous_sector_allocator.sv
tb/contiguous_sector_allocator_tb.sv
